// ===== design/lfz_pkg.sv =====
// Shared constants, types and the sine table builder for the front-zone speed limiter.
`timescale 1ns / 1ps
`default_nettype none

package lfz_pkg;

    localparam int MAX_POINTS      = 2048;
    localparam int SINE_TABLE_BITS = 10;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = (IDX_W + 1 > 12) ? IDX_W + 1 : 12;
    localparam int TAB_N  = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W = SINE_TABLE_BITS + 1;
    localparam int QDEPTH = 2;

    localparam logic signed [16:0] MIN_RESET  = 17'sd1000;
    localparam logic [15:0]        FULL_SCALE = 16'd5000;
    localparam logic [16:0]        COEFF_FULL = 17'd65536;

    // Configuration register indexes
    localparam logic [2:0] REG_ANGLE_START    = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP     = 3'd1;
    localparam logic [2:0] REG_POINT_COUNT    = 3'd2;
    localparam logic [2:0] REG_STOP_DIST      = 3'd3;
    localparam logic [2:0] REG_SLOW_DIST      = 3'd4;
    localparam logic [2:0] REG_HALF_WIDTH     = 3'd5;
    localparam logic [2:0] REG_INTENSITY_GAIN = 3'd6;
    localparam logic [2:0] REG_RAMP_GAIN      = 3'd7;

    typedef struct packed {
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [11:0] point_count;
        logic [15:0] stop_dist;
        logic [15:0] slow_dist;
        logic [15:0] half_width;
        logic [31:0] intensity_gain;
        logic [31:0] ramp_gain;
    } cfg_t;

    // One classified point on its way from the front to the back
    typedef struct packed {
        logic [15:0]        range_mm;
        logic [15:0]        intensity;
        logic signed [15:0] sin_q15;
        logic signed [15:0] cos_q15;
        logic               mid;
        logic               done;
    } item_t;

    typedef struct packed {
        logic [15:0]        intensity_out;
        logic               in_zone;
        logic               scan_done;
        logic [16:0]        speed_coeff;
        logic signed [16:0] min_front_mm;
    } result_t;

    // Table construction, evaluated at elaboration only
    localparam longint Q30       = 64'sd1073741824;
    localparam longint HalfPiQ30 = 64'sd1686629713;

    typedef logic [14:0] sine_rom_t [TAB_N + 1];

    // Quarter-wave sine in Q1.15 by an integer Taylor series in Q30
    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        longint    th;
        longint    th2;
        longint    term;
        longint    sum;
        longint    v;
        for (int k = 0; k <= TAB_N; k++)
        begin
            th   = (HalfPiQ30 * longint'(k)) / TAB_N;
            th2  = (th * th) / Q30;
            term = th;
            sum  = th;
            // Twelve odd-power terms, each divided by (2n)(2n+1)
            term = -((term * th2) / Q30) / 64'sd6;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd20;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd42;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd72;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd110;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd156;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd210;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd272;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd342;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd420;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd506;
            sum  = sum + term;
            term = -((term * th2) / Q30) / 64'sd600;
            sum  = sum + term;
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (sum + 64'sd16384) / 64'sd32768;
            if (v > 64'sd32767)
            begin
                v = 64'sd32767;
            end
            rom[k] = v[14:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== design/lfz_front.sv =====
// Front end: accepts points, tracks the scan index and looks up sine and cosine.
`timescale 1ns / 1ps
`default_nettype none

module lfz_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lfz_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [15:0]    in_range,
    input  wire logic [15:0]    in_intensity,
    input  wire logic           q_full,
    output logic                q_push,
    output lfz_pkg::item_t      q_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_ROM  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam int IW = lfz_pkg::IDX_W;
    localparam int CW = lfz_pkg::CNT_W;
    localparam int AW = lfz_pkg::ADDR_W;
    localparam int SB = lfz_pkg::SINE_TABLE_BITS;

    localparam lfz_pkg::sine_rom_t SineRom = lfz_pkg::build_sine();

    logic [1:0]        state_reg;
    logic [IW-1:0]     index_reg;
    logic [15:0]       range_reg;
    logic [15:0]       inten_reg;
    logic              mid_reg;
    logic              done_reg;
    logic [15:0]       angle_reg;
    logic [14:0]       sin_raw_reg;
    logic [14:0]       cos_raw_reg;
    logic              sin_neg_reg;
    logic              cos_neg_reg;

    logic              accept;
    logic [CW-1:0]     count_ext;
    logic [CW-1:0]     n_eff;
    logic [CW-1:0]     idx_ext;
    logic              done_now;
    logic              mid_now;
    logic [IW+15:0]    aprod;
    logic [15:0]       angle_now;
    logic [1:0]        sin_quad;
    logic [1:0]        cos_quad;
    logic [SB-1:0]     tab_idx;
    logic [AW-1:0]     sin_addr;
    logic [AW-1:0]     cos_addr;

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;

    // Effective point count: zero reads as one, clamp to table of indexes
    always_comb
    begin
        count_ext = CW'(cfg.point_count);
        if (count_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (count_ext > CW'(lfz_pkg::MAX_POINTS))
        begin
            n_eff = CW'(lfz_pkg::MAX_POINTS);
        end
        else
        begin
            n_eff = count_ext;
        end
        idx_ext  = CW'(index_reg);
        done_now = (idx_ext >= n_eff - CW'(1));
        mid_now  = (idx_ext == (n_eff >> 1));
    end

    assign aprod     = (IW + 16)'(index_reg) * (IW + 16)'(cfg.angle_step);
    assign angle_now = cfg.angle_start + aprod[15:0];

    // Cosine is the sine a quarter turn on: same in-quadrant index, next quadrant
    assign sin_quad = angle_reg[15:14];
    assign cos_quad = sin_quad + 2'd1;
    assign tab_idx  = angle_reg[13 -: SB];
    assign sin_addr = sin_quad[0] ? AW'(lfz_pkg::TAB_N) - {1'b0, tab_idx} : {1'b0, tab_idx};
    assign cos_addr = cos_quad[0] ? AW'(lfz_pkg::TAB_N) - {1'b0, tab_idx} : {1'b0, tab_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            index_reg <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_ROM;
                        index_reg <= done_now ? '0 : index_reg + IW'(1);
                    end
                end
                F_ROM:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg <= in_range;
            inten_reg <= in_intensity;
            mid_reg   <= mid_now;
            done_reg  <= done_now;
            angle_reg <= angle_now;
        end
        if (state_reg == F_ROM)
        begin
            sin_raw_reg <= SineRom[sin_addr];
            cos_raw_reg <= SineRom[cos_addr];
            sin_neg_reg <= sin_quad[1];
            cos_neg_reg <= cos_quad[1];
        end
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_item.range_mm  = range_reg;
        q_item.intensity = inten_reg;
        q_item.sin_q15   = sin_neg_reg ? -$signed({1'b0, sin_raw_reg}) : $signed({1'b0, sin_raw_reg});
        q_item.cos_q15   = cos_neg_reg ? -$signed({1'b0, cos_raw_reg}) : $signed({1'b0, cos_raw_reg});
        q_item.mid       = mid_reg;
        q_item.done      = done_reg;
    end

endmodule

`default_nettype wire

// ===== design/lfz_queue.sv =====
// Short queue of classified points between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module lfz_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lfz_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output lfz_pkg::item_t       pop_item,
    output logic                 not_empty
);

    localparam int PW = (lfz_pkg::QDEPTH > 1) ? $clog2(lfz_pkg::QDEPTH) : 1;
    localparam int NW = $clog2(lfz_pkg::QDEPTH + 1);

    lfz_pkg::item_t slot_reg [lfz_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [NW-1:0]  count_reg;

    assign full      = (count_reg == NW'(lfz_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(lfz_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(lfz_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue written while full");

endmodule

`default_nettype wire

// ===== design/lfz_back.sv =====
// Back end: coordinates, zone test, intensity rewrite, scan minimum and speed coefficient.
`timescale 1ns / 1ps
`default_nettype none

module lfz_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lfz_pkg::cfg_t   cfg,
    input  wire logic            q_valid,
    input  wire lfz_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lfz_pkg::result_t     out_result
);

    localparam logic [1:0] B_XY   = 2'd0;
    localparam logic [1:0] B_ZONE = 2'd1;
    localparam logic [1:0] B_FIN  = 2'd2;

    logic [1:0]              state_reg;
    lfz_pkg::item_t          item_reg;
    logic signed [31:0]      prodx_reg;
    logic signed [31:0]      prody_reg;
    logic [47:0]             gprod_reg;
    logic                    zone_reg;
    logic                    xpos_reg;
    logic signed [16:0]      min_reg;
    logic                    out_valid_reg;
    lfz_pkg::result_t        res_reg;

    logic signed [16:0]      x_val;
    logic signed [16:0]      y_val;
    logic signed [17:0]      x18;
    logic signed [17:0]      y18;
    logic signed [17:0]      hw18;
    logic signed [17:0]      slow18;
    logic signed [17:0]      stop18;
    logic signed [17:0]      min18;
    logic                    zone_next;
    logic [15:0]             diff16;
    logic [47:0]             cprod;
    logic [31:0]             ramp_q;
    logic [16:0]             coeff_next;
    logic [15:0]             iout_next;
    logic                    out_write;
    lfz_pkg::result_t        res_next;

    assign q_pop = (state_reg == B_XY) && q_valid;

    // Floor of the Q15 product is an arithmetic shift
    assign x_val  = prodx_reg[31:15];
    assign y_val  = prody_reg[31:15];
    assign x18    = {x_val[16], x_val};
    assign y18    = {y_val[16], y_val};
    assign hw18   = $signed({2'b00, cfg.half_width});
    assign slow18 = $signed({2'b00, cfg.slow_dist});
    assign stop18 = $signed({2'b00, cfg.stop_dist});
    assign min18  = {min_reg[16], min_reg};

    assign zone_next = (item_reg.intensity != '0) && (y18 < hw18) && (y18 > -hw18)
                       && (x18 < slow18);

    // Speed coefficient: zero but on the last point of a scan, else ramp between stop and slow distances
    always_comb
    begin
        diff16 = 16'(min18 - stop18);
        cprod  = 48'(diff16) * 48'(cfg.ramp_gain);
        ramp_q = cprod[47:16];
        if (!item_reg.done)
        begin
            coeff_next = '0;
        end
        else if (min18 <= stop18)
        begin
            coeff_next = '0;
        end
        else if (min18 > slow18)
        begin
            coeff_next = lfz_pkg::COEFF_FULL;
        end
        else if (ramp_q > 32'(lfz_pkg::COEFF_FULL))
        begin
            coeff_next = lfz_pkg::COEFF_FULL;
        end
        else
        begin
            coeff_next = ramp_q[16:0];
        end
    end

    always_comb
    begin
        if (!zone_reg)
        begin
            iout_next = item_reg.intensity;
        end
        else if (!xpos_reg)
        begin
            iout_next = '0;
        end
        else if (gprod_reg[47:32] != '0)
        begin
            iout_next = 16'hFFFF;
        end
        else
        begin
            iout_next = gprod_reg[31:16];
        end
        if (item_reg.mid)
        begin
            iout_next = lfz_pkg::FULL_SCALE;
        end
    end

    always_comb
    begin
        res_next.intensity_out = iout_next;
        res_next.in_zone       = zone_reg;
        res_next.scan_done     = item_reg.done;
        res_next.speed_coeff   = coeff_next;
        res_next.min_front_mm  = min_reg;
    end

    assign out_write = (state_reg == B_FIN) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_XY;
            min_reg       <= lfz_pkg::MIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_XY:
                begin
                    if (q_valid)
                    begin
                        state_reg <= B_ZONE;
                    end
                end
                B_ZONE:
                begin
                    state_reg <= B_FIN;
                    if (zone_next && (x_val < min_reg))
                    begin
                        min_reg <= x_val;
                    end
                end
                B_FIN:
                begin
                    if (out_write)
                    begin
                        state_reg <= B_XY;
                        // Restart the scan minimum after the last point
                        if (item_reg.done)
                        begin
                            min_reg <= lfz_pkg::MIN_RESET;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_XY;
                end
            endcase
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg  <= q_item;
            prodx_reg <= $signed({16'b0, q_item.range_mm})
                         * $signed({{16{q_item.cos_q15[15]}}, q_item.cos_q15});
            prody_reg <= $signed({16'b0, q_item.range_mm})
                         * $signed({{16{q_item.sin_q15[15]}}, q_item.sin_q15});
        end
        if (state_reg == B_ZONE)
        begin
            zone_reg  <= zone_next;
            xpos_reg  <= (x_val > 17'sd0);
            gprod_reg <= 48'(x_val[15:0]) * 48'(cfg.intensity_gain);
        end
        if (out_write)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    a_min_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= lfz_pkg::MIN_RESET)
        else $error("scan minimum above its restart value");

    a_coeff_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.scan_done) |-> (res_reg.speed_coeff == '0))
        else $error("speed coefficient on a point that is not last");

    a_coeff_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.speed_coeff <= lfz_pkg::COEFF_FULL))
        else $error("speed coefficient above full speed");

    a_one_pop_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == B_ZONE))
        else $error("point taken without entering the zone step");

endmodule

`default_nettype wire

// ===== design/lidar_front_zone_speed_limiter.sv =====
// Top level: configuration registers, front, queue and back of the speed limiter.
// A point passes the front's accept, sine ROM read and queue push states, then the
// back's coordinate, zone and coefficient steps; the front takes no new point until
// the last is pushed, and a full queue or a busy output holds the flow.
// Reset: asynchronous, active low; clears the point index, sets the scan minimum to
// 1000 mm and loads the configuration defaults. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lidar_front_zone_speed_limiter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] range_mm, [31:16] intensity_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [15:0] intensity_out, [32:16] speed_coeff,
                                        // [49:33] min_front_mm, [55:50] zero
    output logic             m_tlast,
    output logic             m_tuser    // [0] in_zone
);

    localparam lfz_pkg::cfg_t CfgReset = '{
        angle_start:    16'd0,
        angle_step:     16'd182,
        point_count:    12'd360,
        stop_dist:      16'd300,
        slow_dist:      16'd600,
        half_width:     16'd400,
        intensity_gain: 32'd546133,
        ramp_gain:      32'd14316558
    };

    lfz_pkg::cfg_t    cfg_reg;
    lfz_pkg::item_t   f_item;
    lfz_pkg::item_t   q_item;
    lfz_pkg::result_t result;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfz_pkg::REG_ANGLE_START:    cfg_reg.angle_start    <= cfg_data[15:0];
                lfz_pkg::REG_ANGLE_STEP:     cfg_reg.angle_step     <= cfg_data[15:0];
                lfz_pkg::REG_POINT_COUNT:    cfg_reg.point_count    <= cfg_data[11:0];
                lfz_pkg::REG_STOP_DIST:      cfg_reg.stop_dist      <= cfg_data[15:0];
                lfz_pkg::REG_SLOW_DIST:      cfg_reg.slow_dist      <= cfg_data[15:0];
                lfz_pkg::REG_HALF_WIDTH:     cfg_reg.half_width     <= cfg_data[15:0];
                lfz_pkg::REG_INTENSITY_GAIN: cfg_reg.intensity_gain <= cfg_data;
                lfz_pkg::REG_RAMP_GAIN:      cfg_reg.ramp_gain      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lfz_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_range     (s_tdata[15:0]),
        .in_intensity (s_tdata[31:16]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (f_item)
    );

    lfz_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    lfz_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {6'b0, result.min_front_mm, result.speed_coeff, result.intensity_out};
    assign m_tlast = result.scan_done;
    assign m_tuser = result.in_zone;

endmodule

`default_nettype wire
